// ===== sv/jdr_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the joystick direction repeat block
// no dependencies

package jdr_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_DEAD_ZONE    = 2'd0;
   localparam logic [1:0] CSR_DOMINANCE    = 2'd1;
   localparam logic [1:0] CSR_INITIAL_DLY  = 2'd2;
   localparam logic [1:0] CSR_REPEAT_PER   = 2'd3;

   // configuration reset values
   localparam logic [15:0] DEAD_ZONE_RST   = 16'd16384;
   localparam logic [15:0] DOMINANCE_RST   = 16'd4096;
   localparam logic [15:0] INITIAL_DLY_RST = 16'd300;
   localparam logic [15:0] REPEAT_PER_RST  = 16'd150;

   // held axis encoding, two's complement sign
   localparam logic [1:0] AXIS_CENTER = 2'd0;
   localparam logic [1:0] AXIS_POS    = 2'd1;
   localparam logic [1:0] AXIS_NEG    = 2'd3;

   // reported direction codes
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic [31:0]        now_ms;
      logic               input_allowed;
   } req_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] direction;
   } rsp_type;

   typedef struct packed {
      logic [15:0] dead_zone_threshold;
      logic [15:0] lead_margin;
      logic [15:0] initial_delay_ms;
      logic [15:0] repeat_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  held_horizontal;
      logic [1:0]  held_vertical;
      logic [31:0] repeat_deadline;
   } hold_type;

endpackage

// ===== sv/jdr_decide.sv =====
`timescale 1ns / 1ps
// direction decision and repeat timing for one joystick sample
// depends on jdr_pkg

module jdr_decide
   import jdr_pkg::*;
(
   input  req_type  sample,
   input  cfg_type  cfg,
   input  hold_type hold,
   output hold_type hold_next,
   output rsp_type  result
);

   logic [16:0] raw_x, raw_y;
   logic [16:0] mag_x, mag_y;
   logic [16:0] thr;
   logic [17:0] x_plus_m, y_plus_m;
   logic        x_ok, y_ok, pref_x, pref_y;
   logic [1:0]  h, v, code;
   logic        changed, centered;
   logic [31:0] since_deadline;
   logic        due;

   assign raw_x = {1'b0, sample.axis_x};
   assign raw_y = {1'b0, sample.axis_y};
   // most negative value gives magnitude 32768
   assign mag_x = sample.axis_x[15] ? 17'(17'h10000 - raw_x) : raw_x;
   assign mag_y = sample.axis_y[15] ? 17'(17'h10000 - raw_y) : raw_y;
   assign thr   = {1'b0, cfg.dead_zone_threshold};

   assign x_plus_m = {1'b0, mag_x} + {2'b00, cfg.lead_margin};
   assign y_plus_m = {1'b0, mag_y} + {2'b00, cfg.lead_margin};

   assign x_ok = mag_x >= thr;
   assign y_ok = mag_y >= thr;

   // held axis keeps priority until the other one leads by the margin
   assign pref_x = x_ok && (({1'b0, mag_x} >= y_plus_m) ||
                  ((hold.held_horizontal != AXIS_CENTER) && ({1'b0, mag_y} < x_plus_m)));
   assign pref_y = y_ok && (({1'b0, mag_y} >= x_plus_m) ||
                  ((hold.held_vertical != AXIS_CENTER) && ({1'b0, mag_x} < y_plus_m)));

   always_comb begin
      h = AXIS_CENTER;
      v = AXIS_CENTER;
      if (pref_x || (!pref_y && x_ok && (mag_x >= mag_y))) begin
         h = sample.axis_x[15] ? AXIS_NEG : AXIS_POS;
      end else if (pref_y || y_ok) begin
         v = sample.axis_y[15] ? AXIS_NEG : AXIS_POS;
      end
   end

   always_comb begin
      if (h == AXIS_NEG) begin
         code = DIR_LEFT;
      end else if (h == AXIS_POS) begin
         code = DIR_RIGHT;
      end else if (v == AXIS_NEG) begin
         code = DIR_UP;
      end else begin
         code = DIR_DOWN;
      end
   end

   assign changed        = (h != hold.held_horizontal) || (v != hold.held_vertical);
   assign centered       = (h == AXIS_CENTER) && (v == AXIS_CENTER);
   assign since_deadline = sample.now_ms - hold.repeat_deadline;
   // wrapping compare: due once the difference is non-negative
   assign due            = !since_deadline[31];

   always_comb begin
      hold_next        = hold;
      hold_next.held_horizontal = h;
      hold_next.held_vertical   = v;
      result.fire      = 1'b0;
      result.direction = DIR_LEFT;
      if (changed) begin
         if (centered) begin
            hold_next.repeat_deadline = '0;
         end else begin
            hold_next.repeat_deadline = sample.now_ms + {16'd0, cfg.initial_delay_ms};
            if (sample.input_allowed) begin
               result.fire      = 1'b1;
               result.direction = code;
            end
         end
      end else if (!centered && sample.input_allowed && due) begin
         hold_next.repeat_deadline = sample.now_ms + {16'd0, cfg.repeat_period_ms};
         result.fire      = 1'b1;
         result.direction = code;
      end
   end

endmodule

// ===== sv/joystick_direction_repeat.sv =====
`timescale 1ns / 1ps
// joystick to four-way direction converter with auto-repeat, top level
// depends on jdr_pkg and jdr_decide
//
//   channel   ports                               beat
//   req       req_valid  req_stall  req_beat      one joystick sample (req_type)
//   rsp       rsp_valid  rsp_stall  rsp_beat      one result, fire + direction (rsp_type)
//   csr       csr_write_en csr_index csr_wdata    one register write, no read-back
//
// a sample sits in the input register while the decision logic works on it,
// and its result moves into the result register when the decision stage advances; one sample
// per cycle is sustained while rsp_stall is low, set by the held-state update
// in jdr_decide; reset is synchronous and active high: configuration registers
// go to their reset values, held direction centered, deadline zero, both stages empty
// rsp_stall holds the result register and, through it, the input register;
// req_stall rises only when the input register is full and cannot move on

module joystick_direction_repeat
   import jdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_beat,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_beat,

   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration
   cfg_type  cfg_ff, cfg_in;

   // input register
   logic     in_valid_ff, in_valid_in;
   req_type  in_beat_ff, in_beat_in;

   // held direction and repeat deadline
   hold_type hold_ff, hold_in, hold_next;

   // result register
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_beat_ff, out_beat_in;
   rsp_type  result;

   logic     advance;
   logic     req_take;

   // the decision stage moves when the result register is empty or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   jdr_decide u_decide (
      .sample    (in_beat_ff),
      .cfg       (cfg_ff),
      .hold      (hold_ff),
      .hold_next (hold_next),
      .result    (result)
   );

   // register writes, index decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEAD_ZONE:   cfg_in.dead_zone_threshold = csr_wdata;
            CSR_DOMINANCE:   cfg_in.lead_margin         = csr_wdata;
            CSR_INITIAL_DLY: cfg_in.initial_delay_ms    = csr_wdata;
            CSR_REPEAT_PER:  cfg_in.repeat_period_ms    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      // input register can take a new sample whenever it is empty or moves on
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_beat_in  = req_take ? req_beat : in_beat_ff;

      // held state only changes when a sample is consumed
      hold_in = advance ? hold_next : hold_ff;

      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_beat_in  = advance ? result : out_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone_threshold <= DEAD_ZONE_RST;
         cfg_ff.lead_margin         <= DOMINANCE_RST;
         cfg_ff.initial_delay_ms    <= INITIAL_DLY_RST;
         cfg_ff.repeat_period_ms    <= REPEAT_PER_RST;
         hold_ff.held_horizontal    <= AXIS_CENTER;
         hold_ff.held_vertical      <= AXIS_CENTER;
         hold_ff.repeat_deadline    <= '0;
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         hold_ff      <= hold_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_beat_ff  <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

endmodule
